>>> rtl/p2rgba_pkg.sv
// Package: shared types, format codes and widening tables for the pixel converter.
`timescale 1ns / 1ps
`default_nettype none

package p2rgba_pkg;

    // Source format codes, as written to the format register.
    typedef logic [2:0] fmt_t;

    localparam fmt_t FMT_RGBA8888 = 3'd0;
    localparam fmt_t FMT_BGRA8888 = 3'd1;
    localparam fmt_t FMT_RGB565   = 3'd2;
    localparam fmt_t FMT_RGB888   = 3'd3;
    localparam fmt_t FMT_ALPHA8   = 3'd4;

    localparam logic [7:0] CHAN_MAX = 8'd255;
    localparam int Chan5Max = 31;
    localparam int Chan6Max = 63;

    // One converted pixel, before the row mark is attached.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       format_error;
    } rgba_t;

    typedef logic [7:0] widen5_tab_t [32];
    typedef logic [7:0] widen6_tab_t [64];

    function automatic widen5_tab_t build_widen5();
        widen5_tab_t tab;
        for (int i = 0; i < 32; i++) begin
            tab[i] = 8'((i * 255) / Chan5Max);
        end
        return tab;
    endfunction

    function automatic widen6_tab_t build_widen6();
        widen6_tab_t tab;
        for (int i = 0; i < 64; i++) begin
            tab[i] = 8'((i * 255) / Chan6Max);
        end
        return tab;
    endfunction

    // Truncated c*255/31 and c*255/63, built at elaboration.
    localparam widen5_tab_t WIDEN5 = build_widen5();
    localparam widen6_tab_t WIDEN6 = build_widen6();

    // Truncated c*a/255. The product is below 65536, where
    // (p + (p >> 8) + 1) >> 8 equals floor(p / 255) exactly.
    function automatic logic [7:0] premul_f(input logic [7:0] c, input logic [7:0] a);
        logic [15:0] prod;
        logic [15:0] sum;
        prod = 16'(c) * 16'(a);
        sum  = prod + {8'd0, prod[15:8]} + 16'd1;
        return sum[15:8];
    endfunction

endpackage

`default_nettype wire

>>> rtl/pixel_to_rgba_premultiply.sv
// Top level of the pixel format converter to premultiplied RGBA8888.
`timescale 1ns / 1ps
`default_nettype none

// Converts one source pixel word per clock into an RGBA8888 pixel with
// premultiplied alpha. A word is taken at each rising edge where start is
// high; busy is always low, so a new word may be offered in every cycle and
// the block sustains one pixel per clock. Each result passes through the input
// register and the result register, and is held for exactly one cycle with
// done high; the receiver cannot stall it and must take it in that cycle. The
// format decode, the 8x8 channel multiplies and the divide-by-255 shift-add
// lie between the input register and the result register. The source format
// is set through the APB port at byte address 0 (0 RGBA8888, 1 BGRA8888,
// 2 RGB565, 3 RGB888, 4 ALPHA8); the other codes give zero channels with
// format_error set. The format travels with each word, but it should only be
// changed while no words are in flight. RGBA8888 and BGRA8888 are
// premultiplied as c*a/255, truncated; RGB565 channels are widened with
// c*255/31 or c*255/63, truncated. The row_end mark comes out unchanged in
// row_end_out alongside its pixel.
module pixel_to_rgba_premultiply (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Command channel
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] pixel_word,
    input  wire logic        row_end,
    // Result channel
    output logic             done,
    output logic [7:0]       red,
    output logic [7:0]       green,
    output logic [7:0]       blue,
    output logic [7:0]       alpha,
    output logic             format_error,
    output logic             row_end_out,
    // APB configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import p2rgba_pkg::*;

    // Word address of the format register.
    localparam logic REG_SOURCE_FORMAT = 1'b0;

    fmt_t        fmt_reg;
    fmt_t        fmt_next;
    logic        cfg_write;

    logic        accept;
    logic        in_valid_reg;
    logic [31:0] pixel_reg;
    logic        row_end_reg;
    fmt_t        in_fmt_reg;

    rgba_t       conv_pixel;
    logic        done_reg;
    rgba_t       res_reg;
    logic        row_end_out_reg;

    // ------------------------------------------------------------------
    // Configuration register. Writes land on the access phase; words above
    // the register map are ignored and read back as zero.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_SOURCE_FORMAT);

    always_comb
    begin
        fmt_next = fmt_reg;
        if (cfg_write)
        begin
            fmt_next = pwdata[2:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= FMT_RGBA8888;
        end
        else
        begin
            fmt_reg <= fmt_next;
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        if (paddr[2] == REG_SOURCE_FORMAT)
        begin
            prdata = {29'd0, fmt_reg};
        end
    end

    // ------------------------------------------------------------------
    // Input register. The block never stalls, so every start is a word.
    // ------------------------------------------------------------------
    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pixel_reg   <= pixel_word;
            row_end_reg <= row_end;
            in_fmt_reg  <= fmt_reg;
        end
    end

    // ------------------------------------------------------------------
    // Conversion between the input and result registers.
    // ------------------------------------------------------------------
    p2rgba_convert u_convert (
        .pixel_word (pixel_reg),
        .fmt        (in_fmt_reg),
        .pixel      (conv_pixel)
    );

    // ------------------------------------------------------------------
    // Result register: one cycle of done per converted word.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            res_reg         <= conv_pixel;
            row_end_out_reg <= row_end_reg;
        end
    end

    assign done         = done_reg;
    assign red          = res_reg.red;
    assign green        = res_reg.green;
    assign blue         = res_reg.blue;
    assign alpha        = res_reg.alpha;
    assign format_error = res_reg.format_error;
    assign row_end_out  = row_end_out_reg;

endmodule

`default_nettype wire

>>> rtl/p2rgba_convert.sv
// Combinational conversion of one source word into a premultiplied RGBA pixel.
`timescale 1ns / 1ps
`default_nettype none

module p2rgba_convert (
    input  wire logic [31:0]       pixel_word,
    input  wire p2rgba_pkg::fmt_t  fmt,
    output p2rgba_pkg::rgba_t      pixel
);
    import p2rgba_pkg::*;

    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;

    assign b0 = pixel_word[7:0];
    assign b1 = pixel_word[15:8];
    assign b2 = pixel_word[23:16];
    assign b3 = pixel_word[31:24];

    always_comb
    begin
        pixel = '0;
        case (fmt)
            FMT_RGBA8888:
            begin
                pixel.alpha = b3;
                pixel.red   = premul_f(b0, b3);
                pixel.green = premul_f(b1, b3);
                pixel.blue  = premul_f(b2, b3);
            end
            FMT_BGRA8888:
            begin
                pixel.alpha = b3;
                pixel.red   = premul_f(b2, b3);
                pixel.green = premul_f(b1, b3);
                pixel.blue  = premul_f(b0, b3);
            end
            FMT_RGB565:
            begin
                pixel.red   = WIDEN5[pixel_word[15:11]];
                pixel.green = WIDEN6[pixel_word[10:5]];
                pixel.blue  = WIDEN5[pixel_word[4:0]];
                pixel.alpha = CHAN_MAX;
            end
            FMT_RGB888:
            begin
                pixel.red   = b0;
                pixel.green = b1;
                pixel.blue  = b2;
                pixel.alpha = CHAN_MAX;
            end
            FMT_ALPHA8:
            begin
                pixel.red   = b0;
                pixel.green = b0;
                pixel.blue  = b0;
                pixel.alpha = b0;
            end
            default:
            begin
                pixel.format_error = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/p2rgba_checker.sv
// Port-level checker for the pixel converter, with its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module p2rgba_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic        row_end,
    input  wire logic        done,
    input  wire logic [7:0]  red,
    input  wire logic [7:0]  green,
    input  wire logic [7:0]  blue,
    input  wire logic [7:0]  alpha,
    input  wire logic        format_error,
    input  wire logic        row_end_out
);

    // Every accepted word produces a result once it has passed the input and result registers.
    a_accept_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("accepted word produced no result two cycles later");

    // No result appears unless a word was accepted into the input register ahead of it.
    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result word without an accepted input word");

    // The row mark follows its own pixel.
    a_row_end_follows: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (row_end_out == $past(row_end, 2)))
        else $error("row_end_out does not match its input word");

    // An unsupported format clears all four channels.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && format_error) |->
            (red == 8'd0 && green == 8'd0 && blue == 8'd0 && alpha == 8'd0))
        else $error("format_error result with nonzero channels");

    // A cycle spent in reset is never followed by a result strobe. The check
    // looks ahead rather than at the reset cycle itself, since at the very first
    // edge the registers may not have seen the reset yet.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !done)
        else $error("done seen during reset");

endmodule

bind pixel_to_rgba_premultiply p2rgba_checker u_p2rgba_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .row_end      (row_end),
    .done         (done),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .alpha        (alpha),
    .format_error (format_error),
    .row_end_out  (row_end_out)
);

`default_nettype wire

>>> dv/tb_top.sv
// Self-checking testbench for the pixel converter to premultiplied RGBA8888.
`timescale 1ns / 1ps

// The testbench pushes source pixel words through the command channel and
// checks every converted word on the result channel against its own
// conversion of the same input. The format register is programmed through the
// APB port only while nothing is in flight. Every code from 0 to 7 is used,
// the unsupported codes among them. A short directed pass comes first: all
// zeros, all ones and one probe word per format. After it come random phases
// of random words, each with a random format. One long phase runs the sender
// with no gaps at all, and the others leave gaps in about a fifth of the
// cycles. The result side cannot be stalled, so only the sender idles.
module tb_top;
    import p2rgba_pkg::*;

    localparam int          LATENCY_SLACK = 8;
    localparam int          CYCLE_LIMIT   = 100000;
    localparam int          RANDOM_WORDS  = 1900;
    localparam int          MAX_REPORTS   = 10;
    localparam int          FULL_SCALE    = 255;
    localparam int          CHAN5_TOP     = 31;
    localparam int          CHAN6_TOP     = 63;
    // The format register is register 0; address 4 would be register 1,
    // which does not exist, so writes there must leave the format alone.
    localparam logic [2:0]  FMT_REG_ADDR  = 3'd0;
    localparam logic [2:0]  SPARE_ADDR    = 3'd4;

    // A converted pixel as the result port shows it, row mark included.
    typedef struct packed {
        rgba_t pix;
        logic  row_mark;
    } rgba_word_t;

    typedef struct packed {
        logic [31:0] word;
        logic        row_mark;
    } src_word_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        start        = 1'b0;
    logic [31:0] pixel_word   = '0;
    logic        row_end      = 1'b0;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [2:0]  paddr        = '0;
    logic [31:0] pwdata       = '0;

    logic        busy;
    logic        done;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        format_error;
    logic        row_end_out;
    logic [31:0] prdata;
    logic        pready;

    // Source words waiting for the driver, and converted words that the
    // block still owes us, oldest first.
    src_word_t   pixel_queue[$];
    rgba_word_t  owed_pixels[$];

    // Copy of the format register, changed only while the block is idle.
    fmt_t        format_shadow = FMT_RGBA8888;
    int          idle_pct      = 19;
    int          mismatch_count = 0;
    int          cycle_count    = 0;

    pixel_to_rgba_premultiply dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .pixel_word   (pixel_word),
        .row_end      (row_end),
        .done         (done),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .alpha        (alpha),
        .format_error (format_error),
        .row_end_out  (row_end_out),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 clk = ~clk;

    // Truncated c*a/255 for the straight-alpha formats.
    function automatic logic [7:0] scale_by_alpha(input logic [7:0] c, input logic [7:0] a);
        int unsigned prod;
        prod = int'(c) * int'(a);
        return 8'(prod / FULL_SCALE);
    endfunction

    // Converts one source word under the given format the way the block must.
    function automatic rgba_word_t convert_pixel(input fmt_t fmt, input logic [31:0] w,
                                                 input logic mark);
        rgba_word_t res;
        res          = '0;
        res.row_mark = mark;
        case (fmt)
            FMT_RGBA8888: begin
                res.pix.alpha = w[31:24];
                res.pix.red   = scale_by_alpha(w[7:0], w[31:24]);
                res.pix.green = scale_by_alpha(w[15:8], w[31:24]);
                res.pix.blue  = scale_by_alpha(w[23:16], w[31:24]);
            end
            FMT_BGRA8888: begin
                // Red and blue trade places before the premultiply.
                res.pix.alpha = w[31:24];
                res.pix.red   = scale_by_alpha(w[23:16], w[31:24]);
                res.pix.green = scale_by_alpha(w[15:8], w[31:24]);
                res.pix.blue  = scale_by_alpha(w[7:0], w[31:24]);
            end
            FMT_RGB565: begin
                // Only the low half word counts; each channel is stretched to
                // the full 8-bit range and truncated.
                res.pix.red   = 8'((int'(w[15:11]) * FULL_SCALE) / CHAN5_TOP);
                res.pix.green = 8'((int'(w[10:5]) * FULL_SCALE) / CHAN6_TOP);
                res.pix.blue  = 8'((int'(w[4:0]) * FULL_SCALE) / CHAN5_TOP);
                res.pix.alpha = 8'(FULL_SCALE);
            end
            FMT_RGB888: begin
                res.pix.red   = w[7:0];
                res.pix.green = w[15:8];
                res.pix.blue  = w[23:16];
                res.pix.alpha = 8'(FULL_SCALE);
            end
            FMT_ALPHA8: begin
                res.pix.red   = w[7:0];
                res.pix.green = w[7:0];
                res.pix.blue  = w[7:0];
                res.pix.alpha = w[7:0];
            end
            default: begin
                // Unsupported code: channels stay zero, only the flag is set.
                res.pix.format_error = 1'b1;
            end
        endcase
        return res;
    endfunction

    // APB write: a setup cycle, then an access cycle that ends at the edge
    // where the register takes the data.
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == FMT_REG_ADDR) format_shadow = data[2:0];
    endtask

    // Reads the format register back. prdata is sampled on the falling edge
    // inside the access cycle, where it is settled.
    task automatic check_format_readback();
        logic [31:0] seen;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= FMT_REG_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        while (!pready) @(negedge clk);
        seen = prdata;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (seen !== {29'd0, format_shadow}) begin
            if (mismatch_count < MAX_REPORTS)
                $display("format readback: expected %0d, got %h", format_shadow, seen);
            mismatch_count++;
        end
    endtask

    // Blocks until the driver has handed over every word and the block has
    // returned every converted word, so the format may be changed.
    task automatic wait_until_drained();
        while (pixel_queue.size() != 0 || start || owed_pixels.size() != 0)
            @(posedge clk);
    endtask

    // Driver. A word is taken at an edge with start high and busy low; at that
    // edge its conversion is queued and the next word, if any, is offered
    // unless this cycle is chosen as a gap. A word offered while busy is held.
    always @(posedge clk or negedge rst_n) begin
        src_word_t nxt;
        if (!rst_n) begin
            start      <= 1'b0;
            pixel_word <= '0;
            row_end    <= 1'b0;
        end else if (!(start && busy)) begin
            if (start) begin
                owed_pixels.push_back(convert_pixel(format_shadow, pixel_word, row_end));
                void'(pixel_queue.pop_front());
            end
            if (pixel_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
                nxt        = pixel_queue[0];
                start      <= 1'b1;
                pixel_word <= nxt.word;
                row_end    <= nxt.row_mark;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor. Each word marked by done is matched against the oldest owed
    // conversion; a word that nobody asked for is a failure too.
    always @(posedge clk) begin
        rgba_word_t seen;
        rgba_word_t want;
        if (rst_n && done) begin
            seen = '{pix: '{red: red, green: green, blue: blue, alpha: alpha,
                            format_error: format_error},
                     row_mark: row_end_out};
            if (owed_pixels.size() == 0) begin
                if (mismatch_count < MAX_REPORTS)
                    $display("unexpected result word at cycle %0d", cycle_count);
                mismatch_count++;
            end else begin
                want = owed_pixels.pop_front();
                if (seen !== want) begin
                    if (mismatch_count < MAX_REPORTS)
                        $display("pixel mismatch: expected r%h g%h b%h a%h err%b row%b, got r%h g%h b%h a%h err%b row%b",
                                 want.pix.red, want.pix.green, want.pix.blue, want.pix.alpha,
                                 want.pix.format_error, want.row_mark,
                                 seen.pix.red, seen.pix.green, seen.pix.blue, seen.pix.alpha,
                                 seen.pix.format_error, seen.row_mark);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: a run that reaches CYCLE_LIMIT is reported as failed.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        logic [31:0] probe_words [8];
        logic [31:0] wdata;
        logic [31:0] w;
        fmt_t        fmt;
        int          random_sent;
        int          phase_len;
        int          pick;
        bit          first_phase;

        // One probe per format code: alpha zero under RGBA, alpha half under
        // BGRA, a 565 pixel with green empty and junk above it, and so on.
        probe_words = '{32'h00FF_FFFF, 32'h80C0_4001, 32'hFFFF_F81F, 32'hFF12_3456,
                        32'h0000_0080, 32'h1234_5678, 32'h8765_4321, 32'hA5A5_A5A5};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The register must come out of reset as RGBA8888.
        check_format_readback();

        // Directed pass: every format code with both extremes and its probe.
        for (int f = 0; f < 8; f++) begin
            apb_write(FMT_REG_ADDR, 32'(f));
            check_format_readback();
            pixel_queue.push_back('{word: 32'h0000_0000, row_mark: 1'b0});
            pixel_queue.push_back('{word: 32'hFFFF_FFFF, row_mark: 1'b1});
            pixel_queue.push_back('{word: probe_words[f], row_mark: f[0]});
            wait_until_drained();
        end

        // Random phases. The first one is long and runs without gaps, and it
        // always tries the nonexistent register; later ones do so now and then.
        random_sent = 0;
        first_phase = 1'b1;
        while (random_sent < RANDOM_WORDS) begin
            pick = $urandom_range(9);
            if (pick > 7)
                fmt = (pick == 8) ? FMT_RGBA8888 : FMT_BGRA8888;
            else
                fmt = fmt_t'(pick);
            phase_len = first_phase ? 300 : $urandom_range(40, 160);
            idle_pct  = first_phase ? 0 : 19;

            // Upper data bits are junk; only the low three reach the register.
            wdata      = $urandom();
            wdata[2:0] = fmt;
            apb_write(FMT_REG_ADDR, wdata);
            if (first_phase || $urandom_range(3) == 0)
                apb_write(SPARE_ADDR, $urandom());
            check_format_readback();

            for (int i = 0; i < phase_len; i++) begin
                w = $urandom();
                // Push alpha to its extremes now and then.
                case ($urandom_range(7))
                    0: w[31:24] = 8'h00;
                    1: w[31:24] = 8'hFF;
                    default: ;
                endcase
                pixel_queue.push_back('{word: w, row_mark: 1'($urandom_range(1))});
            end
            random_sent += phase_len;
            first_phase  = 1'b0;
            wait_until_drained();
        end

        // Give a stray extra word time to show up before judging.
        repeat (LATENCY_SLACK) @(posedge clk);
        if (mismatch_count == 0 && owed_pixels.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> filelist.f
rtl/p2rgba_pkg.sv
rtl/p2rgba_convert.sv
rtl/pixel_to_rgba_premultiply.sv
rtl/p2rgba_checker.sv
dv/tb_top.sv
